// File: rtl/rcrf_pkg.sv
// rcrf_pkg: shared types and constants for the rectangular collimator ray filter
// used by every rtl file through scoped names
`default_nettype none
package rcrf_pkg;

    localparam int HistW  = 48;
    localparam int ProdW  = 64;   // |d| (32 bit) times dz (33 bit) fits in 64 bit
    localparam int DivW   = 64;   // quotient width
    localparam int DivCntW = 7;

    localparam logic [HistW-1:0] HistMax = {HistW{1'b1}};

    localparam logic [2:0] CFG_Z_ENTRY = 3'd0;
    localparam logic [2:0] CFG_Z_EXIT  = 3'd1;
    localparam logic [2:0] CFG_EN_WX   = 3'd2;
    localparam logic [2:0] CFG_EN_WY   = 3'd3;
    localparam logic [2:0] CFG_EX_WX   = 3'd4;
    localparam logic [2:0] CFG_EX_WY   = 3'd5;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] dir_u;
        logic signed [31:0] dir_v;
        logic signed [31:0] dir_w;
        logic [47:0]        hist_increment;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic signed [31:0] out_w;
        logic [47:0]        out_hist_increment;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input word
        logic sel_exit;    // 1: project to exit plane, 0: entry plane
        logic sel_y;       // 1: y coordinate, 0: x
        logic mul_start;   // start the divider on the registered product
        logic chk;         // check result of the division, update ok flag
        logic clr_ok;      // set ok flag before a plane
        logic save;        // store projected coordinate for output
        logic emit;        // write output register and clear pending
        logic drop;        // add increment to pending
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic w_nonneg;
        logic below_exit;  // z <= z_exit
        logic above_entry; // z > z_entry
        logic div_done;
        logic ok;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/rcrf_div.sv
// rcrf_div: restoring divider, one quotient bit per cycle
// uses rcrf_pkg widths
`default_nettype none
module rcrf_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [rcrf_pkg::ProdW-1:0] dividend,
    input  wire logic [31:0]               divisor,
    output logic                           done,
    output logic [rcrf_pkg::DivW-1:0]      quotient
);
    logic [rcrf_pkg::DivW-1:0]    q_reg, q_next;
    logic [32:0]                  r_reg, r_next;
    logic [31:0]                  d_reg, d_next;
    logic [rcrf_pkg::DivCntW-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [33:0]                  trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {r_reg, q_reg[rcrf_pkg::DivW-1]} - {2'b00, d_reg};
            if (!trial[33]) begin
                r_next = trial[32:0];
                q_next = {q_reg[rcrf_pkg::DivW-2:0], 1'b1};
            end else begin
                r_next = {r_reg[31:0], q_reg[rcrf_pkg::DivW-1]};
                q_next = {q_reg[rcrf_pkg::DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rcrf_pkg::DivCntW'(rcrf_pkg::DivW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

// File: rtl/rcrf_datapath.sv
// rcrf_datapath: input capture, projection multiply, divider, aperture test,
// pending history and output register; uses rcrf_pkg and rcrf_div
`default_nettype none
module rcrf_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_idx,
    input  wire logic [31:0]         cfg_data,
    input  wire rcrf_pkg::in_word_t  s_word,
    input  wire rcrf_pkg::dp_cmd_t   cmd,
    output rcrf_pkg::dp_stat_t       stat,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output rcrf_pkg::out_word_t      m_word
);
    logic signed [31:0] z_entry_reg, z_exit_reg;
    logic [30:0]        en_wx_reg, en_wy_reg, ex_wx_reg, ex_wy_reg;
    rcrf_pkg::in_word_t in_reg;
    logic [47:0]        pend_reg;
    logic [63:0]        prod_reg;
    logic signed [31:0] px_reg;
    logic               ok_reg;
    rcrf_pkg::out_word_t out_reg;
    logic               ovalid_reg;

    logic signed [31:0] zpl, coord, dsel;
    logic [32:0]        dz;
    logic [31:0]        dmag, wmag;
    logic [63:0]        q;
    logic               div_done;
    logic signed [65:0] r;
    logic [65:0]        rmag;
    logic [30:0]        width;
    logic               in_ap;
    logic [48:0]        hsum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_entry_reg <= '0;
            z_exit_reg  <= '0;
            en_wx_reg   <= '0;
            en_wy_reg   <= '0;
            ex_wx_reg   <= '0;
            ex_wy_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                rcrf_pkg::CFG_Z_ENTRY: z_entry_reg <= cfg_data;
                rcrf_pkg::CFG_Z_EXIT:  z_exit_reg  <= cfg_data;
                rcrf_pkg::CFG_EN_WX:   en_wx_reg   <= cfg_data[30:0];
                rcrf_pkg::CFG_EN_WY:   en_wy_reg   <= cfg_data[30:0];
                rcrf_pkg::CFG_EX_WX:   ex_wx_reg   <= cfg_data[30:0];
                rcrf_pkg::CFG_EX_WY:   ex_wy_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign zpl   = cmd.sel_exit ? z_exit_reg : z_entry_reg;
    // dz is positive whenever the projection is used
    assign dz    = 33'({in_reg.pos_z[31], in_reg.pos_z} - {zpl[31], zpl});
    assign coord = cmd.sel_y ? in_reg.pos_y : in_reg.pos_x;
    assign dsel  = cmd.sel_y ? in_reg.dir_v : in_reg.dir_u;
    assign dmag  = dsel[31] ? 32'(-dsel) : dsel;
    assign wmag  = 32'(-in_reg.dir_w);

    rcrf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mul_start),
        .dividend (prod_reg),
        .divisor  (wmag),
        .done     (div_done),
        .quotient (q)
    );

    // quotient is below 2^63, so the 66 bit sum is exact
    assign r = dsel[31] ? ({{34{coord[31]}}, coord} + {2'b00, q})
                        : ({{34{coord[31]}}, coord} - {2'b00, q});
    assign rmag  = r[65] ? 66'(-r) : 66'(r);
    always_comb begin
        unique case ({cmd.sel_exit, cmd.sel_y})
            2'b00:   width = en_wx_reg;
            2'b01:   width = en_wy_reg;
            2'b10:   width = ex_wx_reg;
            default: width = ex_wy_reg;
        endcase
    end
    assign in_ap = (r >= -66'sd2147483648) && (r <= 66'sd2147483647) &&
                   ({rmag[64:0], 1'b0} < {35'd0, width});

    assign hsum = {1'b0, in_reg.hist_increment} + {1'b0, pend_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cmd.drop)
                pend_reg <= hsum[48] ? rcrf_pkg::HistMax : hsum[47:0];
            else if (cmd.emit)
                pend_reg <= '0;
            if (cmd.emit)
                ovalid_reg <= 1'b1;
            else if (m_ready)
                ovalid_reg <= 1'b0;
        end
        if (cmd.load)
            in_reg <= s_word;
        // the multiply stage: 32 by 33 bit product, registered every cycle and settled before the divider start
        prod_reg <= 64'(dmag * {31'd0, dz});
        if (cmd.clr_ok)
            ok_reg <= 1'b1;
        else if (cmd.chk)
            ok_reg <= ok_reg & in_ap;
        if (cmd.save)
            px_reg <= r[31:0];
        if (cmd.emit) begin
            out_reg.out_u <= in_reg.dir_u;
            out_reg.out_v <= in_reg.dir_v;
            out_reg.out_w <= in_reg.dir_w;
            out_reg.out_hist_increment <= hsum[48] ? rcrf_pkg::HistMax : hsum[47:0];
            if (stat.below_exit) begin
                out_reg.out_x <= in_reg.pos_x;
                out_reg.out_y <= in_reg.pos_y;
                out_reg.out_z <= in_reg.pos_z;
            end else begin
                out_reg.out_x <= px_reg;
                out_reg.out_y <= r[31:0];
                out_reg.out_z <= z_exit_reg;
            end
        end
    end

    assign stat.w_nonneg    = !in_reg.dir_w[31];
    assign stat.below_exit  = !(in_reg.pos_z > z_exit_reg);
    assign stat.above_entry = in_reg.pos_z > z_entry_reg;
    assign stat.div_done    = div_done;
    assign stat.ok          = ok_reg && !(cmd.chk && !in_ap);
    assign stat.out_busy    = ovalid_reg && !m_ready;
    assign m_valid = ovalid_reg;
    assign m_word  = out_reg;
endmodule
`default_nettype wire

// File: rtl/rcrf_ctrl.sv
// rcrf_ctrl: sequencer for one particle: decide, project x and y per plane, emit or drop
// uses rcrf_pkg command and status structs
`default_nettype none
module rcrf_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rcrf_pkg::dp_stat_t stat,
    output rcrf_pkg::dp_cmd_t       cmd
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_START = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_NEXT  = 4'd5;
    localparam logic [3:0] ST_EMIT  = 4'd6;
    localparam logic [3:0] ST_DROP  = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       exit_reg, exit_next;
    logic       y_reg, y_next;

    always_comb begin
        state_next = state_reg;
        exit_next  = exit_reg;
        y_next     = y_reg;
        cmd        = '0;
        cmd.sel_exit = exit_reg;
        cmd.sel_y    = y_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.clr_ok = 1'b1;
                y_next     = 1'b0;
                if (stat.w_nonneg)
                    state_next = ST_DROP;
                else if (stat.below_exit)
                    state_next = ST_EMIT;
                else begin
                    exit_next  = !stat.above_entry;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_START;  // product registers here
            ST_START: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    cmd.chk  = 1'b1;
                    cmd.save = !y_reg;
                    if (!stat.ok)
                        state_next = ST_DROP;
                    else if (!y_reg) begin
                        y_next     = 1'b1;
                        state_next = ST_MUL;
                    end else if (!exit_reg)
                        state_next = ST_NEXT;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_NEXT: begin
                exit_next  = 1'b1;
                y_next     = 1'b0;
                cmd.clr_ok = 1'b1;
                state_next = ST_MUL;
            end
            ST_EMIT: begin
                // after a projection, the divider quotient of the exit y coordinate is still held
                cmd.sel_exit = 1'b1;
                cmd.sel_y    = 1'b1;
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DROP: begin
                cmd.drop   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            exit_reg  <= 1'b0;
            y_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            exit_reg  <= exit_next;
            y_reg     <= y_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/rectangular_collimator_ray_filter_core.sv
// Rectangular collimator ray filter: one particle word in, zero or one word out.
// A particle is dropped early or passed below the exit plane without a
// projection, projected to the exit plane only, or also projected to the entry
// plane first: each projected coordinate runs one pass of the shared 64 step
// bit-serial divider. The output register
// holds a finished word while the next particle is already being worked on.
// Depends on rcrf_pkg, rcrf_ctrl, rcrf_datapath and rcrf_div.
`default_nettype none
module rectangular_collimator_ray_filter_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rcrf_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rcrf_pkg::out_word_t      m_data
);
    rcrf_pkg::dp_cmd_t  cmd;
    rcrf_pkg::dp_stat_t stat;

    rcrf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rcrf_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg_index),
        .cfg_data(cfg_data),
        .s_word  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_word  (m_data)
    );
endmodule
`default_nettype wire

// File: rtl/rcrf_checker.sv
// rcrf_checker: port level checks for the collimator filter core
// bound to rectangular_collimator_ray_filter_core; uses rcrf_pkg
`default_nettype none
module rcrf_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire rcrf_pkg::out_word_t m_data
);
    // a stalled result word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // after taking a word the core lowers s_ready while it decides
    a_no_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken in back to back cycles");

    // a result never shows in the cycle after acceptance when none was pending
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result too early");

    // reset leaves no result pending
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind rectangular_collimator_ray_filter_core rcrf_checker u_rcrf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// File: test/tb.sv
// tb: self-checking testbench for rectangular_collimator_ray_filter_core
// predicts each passed particle word and compares it with the output as a whole word
// depends on rcrf_pkg and the core rtl
`default_nettype none
module tb;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic s_valid;
    logic s_ready;
    rcrf_pkg::in_word_t s_data;
    logic m_valid;
    logic m_ready;
    rcrf_pkg::out_word_t m_data;

    rectangular_collimator_ray_filter_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // shadow of the block registers and pending history
    logic signed [31:0] sh_z_entry, sh_z_exit;
    logic [30:0] sh_en_wx, sh_en_wy, sh_ex_wx, sh_ex_wy;
    logic [47:0] sh_pending;

    rcrf_pkg::in_word_t  particle_q[$];
    rcrf_pkg::out_word_t passed_q[$];
    int send_idle_pct, recv_stall_pct;
    int hold_off;
    int errors;
    int cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? rcrf_pkg::HistMax : s[47:0];
    endfunction

    // shift coordinate along cosine across dz; ok cleared on overflow
    function automatic logic signed [63:0] shift_coord(logic signed [31:0] c,
            logic signed [31:0] d, logic [32:0] dz, logic [31:0] wmag,
            output bit ok);
        logic [31:0] dm;
        logic [63:0] q;
        logic signed [65:0] r;
        dm = d[31] ? -d : d;
        q = ({32'd0, dm} * {31'd0, dz}) / {32'd0, wmag};
        ok = 1'b1;
        if (q > (64'd1 << 34)) ok = 1'b0;
        r = d[31] ? $signed({{34{c[31]}}, c}) + $signed({2'b0, q})
                  : $signed({{34{c[31]}}, c}) - $signed({2'b0, q});
        if (r < -66'sd2147483648 || r > 66'sd2147483647) ok = 1'b0;
        return r[63:0];
    endfunction

    function automatic bit in_aperture(bit ok, logic signed [63:0] r, logic [30:0] w);
        logic [63:0] m;
        if (!ok) return 1'b0;
        m = r[63] ? -r : r;
        return (m << 1) < {33'd0, w};
    endfunction

    // returns 1 and fills the word when the particle passes
    function automatic bit filter_particle(rcrf_pkg::in_word_t p,
            output rcrf_pkg::out_word_t o);
        logic [31:0] wmag;
        logic [32:0] dz;
        logic signed [63:0] px, py;
        bit okx, oky;
        o = '0;
        o.out_x = p.pos_x; o.out_y = p.pos_y; o.out_z = p.pos_z;
        o.out_u = p.dir_u; o.out_v = p.dir_v; o.out_w = p.dir_w;
        if (!p.dir_w[31]) begin
            sh_pending = sat_add(sh_pending, p.hist_increment);
            return 0;
        end
        wmag = -p.dir_w;
        if (p.pos_z > sh_z_exit) begin
            if (p.pos_z > sh_z_entry) begin
                dz = $signed({p.pos_z[31], p.pos_z}) - $signed({sh_z_entry[31], sh_z_entry});
                px = shift_coord(p.pos_x, p.dir_u, dz, wmag, okx);
                py = shift_coord(p.pos_y, p.dir_v, dz, wmag, oky);
                if (!in_aperture(okx, px, sh_en_wx) || !in_aperture(oky, py, sh_en_wy)) begin
                    sh_pending = sat_add(sh_pending, p.hist_increment);
                    return 0;
                end
            end
            dz = $signed({p.pos_z[31], p.pos_z}) - $signed({sh_z_exit[31], sh_z_exit});
            px = shift_coord(p.pos_x, p.dir_u, dz, wmag, okx);
            py = shift_coord(p.pos_y, p.dir_v, dz, wmag, oky);
            if (!in_aperture(okx, px, sh_ex_wx) || !in_aperture(oky, py, sh_ex_wy)) begin
                sh_pending = sat_add(sh_pending, p.hist_increment);
                return 0;
            end
            o.out_x = px[31:0]; o.out_y = py[31:0]; o.out_z = sh_z_exit;
        end
        o.out_hist_increment = sat_add(p.hist_increment, sh_pending);
        sh_pending = '0;
        return 1;
    endfunction

    // driver: feeds particle words, predicting each at acceptance
    always @(posedge aclk) begin
        rcrf_pkg::out_word_t o;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (filter_particle(s_data, o)) passed_q.push_back(o);
                void'(particle_q.pop_front());
            end
            if ((s_valid && !s_ready)) begin
                // hold the word
            end else if ((s_valid && s_ready ? particle_q.size() > 0 : particle_q.size() > 0)
                         && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= (s_valid && s_ready) ? particle_q[0] : particle_q[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: compares passed words with the oldest prediction
    always @(posedge aclk) begin
        rcrf_pkg::out_word_t e;
        if (aresetn) begin
            cycles <= cycles + 1;
            if (m_valid && m_ready) begin
                if (passed_q.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10) $display("unexpected word %h", m_data);
                end else begin
                    e = passed_q.pop_front();
                    if (e !== m_data) begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch: exp %h got %h", e, m_data);
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            rcrf_pkg::CFG_Z_ENTRY: sh_z_entry = val;
            rcrf_pkg::CFG_Z_EXIT:  sh_z_exit = val;
            rcrf_pkg::CFG_EN_WX:   sh_en_wx = val[30:0];
            rcrf_pkg::CFG_EN_WY:   sh_en_wy = val[30:0];
            rcrf_pkg::CFG_EX_WX:   sh_ex_wx = val[30:0];
            rcrf_pkg::CFG_EX_WY:   sh_ex_wy = val[30:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (particle_q.size() > 0 || s_valid || passed_q.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic set_geometry(logic [31:0] ze, logic [31:0] zx, logic [30:0] ewx,
                                logic [30:0] ewy, logic [30:0] xwx, logic [30:0] xwy);
        write_reg(rcrf_pkg::CFG_Z_ENTRY, ze);
        write_reg(rcrf_pkg::CFG_Z_EXIT, zx);
        write_reg(rcrf_pkg::CFG_EN_WX, {1'b0, ewx});
        write_reg(rcrf_pkg::CFG_EN_WY, {1'b0, ewy});
        write_reg(rcrf_pkg::CFG_EX_WX, {1'b0, xwx});
        write_reg(rcrf_pkg::CFG_EX_WY, {1'b0, xwy});
    endtask

    function automatic logic [31:0] rand_cos();
        case ($urandom_range(9))
            0: return 32'h4000_0000;
            1: return 32'hC000_0000;
            2: return $urandom();
            default: return $urandom_range(32'h7FFF_FFFF) - 32'h4000_0000 >>> 0;
        endcase
    endfunction

    // mostly downward particles above the planes so projections are exercised
    function automatic rcrf_pkg::in_word_t rand_particle();
        rcrf_pkg::in_word_t p;
        p.pos_x = $signed($urandom()) >>> $urandom_range(31);
        p.pos_y = $signed($urandom()) >>> $urandom_range(31);
        p.pos_z = ($urandom_range(9) < 7) ? sh_z_entry + ($urandom() >> $urandom_range(31))
                                          : $urandom();
        p.dir_u = $signed(rand_cos()) >>> $urandom_range(8);
        p.dir_v = $signed(rand_cos()) >>> $urandom_range(8);
        p.dir_w = ($urandom_range(9) < 8) ? -($urandom_range(32'h4000_0000, 1))
                                          : rand_cos();
        p.hist_increment = ($urandom_range(19) == 0) ? {$urandom(), 16'hFFFF} | 48'hFFFF_0000_0000
                                                     : {16'd0, $urandom()} >> $urandom_range(31);
        if ($urandom_range(9) == 0) p.hist_increment = 48'({$urandom(), $urandom()});
        return p;
    endfunction

    function automatic rcrf_pkg::in_word_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
            logic [31:0] u, logic [31:0] v, logic [31:0] w, logic [47:0] h);
        rcrf_pkg::in_word_t p;
        p.pos_x = x; p.pos_y = y; p.pos_z = z;
        p.dir_u = u; p.dir_v = v; p.dir_w = w; p.hist_increment = h;
        return p;
    endfunction

    initial begin
        int ph;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
        errors = 0; cycles = 0;
        sh_z_entry = 0; sh_z_exit = 0; sh_en_wx = 0; sh_en_wy = 0;
        sh_ex_wx = 0; sh_ex_wy = 0; sh_pending = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // zero widths after reset: all projected particles dropped
        particle_q.push_back(mk(0, 0, 32'h0001_0000, 0, 0, 32'hC000_0000, 48'd5));
        particle_q.push_back(mk(1, 2, 32'hFFFF_0000, 3, 4, 32'hC000_0000, 48'd7));
        drain();
        set_geometry(32'h0010_0000, 32'hFFF0_0000, 31'h0020_0000, 31'h0020_0000,
                     31'h0040_0000, 31'h0040_0000);
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h1234_5678);
        // level, upward, below exit, pass, entry miss, exit only, overflow, extremes, exit only, exit only
        particle_q.push_back(mk(0, 0, 32'h0020_0000, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
        particle_q.push_back(mk(0, 0, 32'h0020_0000, 0, 0, 32'h4000_0000, 48'd1));
        particle_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                32'h4000_0000, 32'hC000_0000, 32'hC000_0000, 48'd2));
        particle_q.push_back(mk(0, 0, 32'h0020_0000, 0, 0, 32'hC000_0000, 48'd3));
        particle_q.push_back(mk(32'h0100_0000, 0, 32'h0020_0000, 0, 0,
                                32'hC000_0000, 48'd4));
        particle_q.push_back(mk(0, 0, 32'h0000_8000, 32'h2000_0000, 0,
                                32'hC000_0000, 48'd5));
        particle_q.push_back(mk(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'hFFFF_FFFF, 48'd6));
        particle_q.push_back(mk(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 48'hFFFF_FFFF_FFFF));
        particle_q.push_back(mk(32'hFFFF_FFFF, 32'h1, 32'h0005_0000, 32'hF000_0000,
                                32'h1000_0000, 32'hC000_0001, 48'd0));
        particle_q.push_back(mk(0, 0, 32'h0000_0000, 0, 0, 32'hFFFF_FFFF, 48'd9));
        drain();
        // swapped planes, maximum widths
        set_geometry(32'h8000_0000, 32'h7FFF_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                     31'h7FFF_FFFF, 31'h7FFF_FFFF);
        particle_q.push_back(mk(0, 0, 32'h7FFF_FFFF, 32'h1000, 32'h1000,
                                32'hC000_0000, 48'd1));
        particle_q.push_back(mk(5, 5, 32'h0, 0, 0, 32'hC000_0000, 48'd1));
        drain();
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            set_geometry(($urandom_range(3) == 0) ? $urandom() : $urandom() >>> 8,
                         -($urandom() >> 8),
                         31'($urandom() >> $urandom_range(1, 12)),
                         31'($urandom() >> $urandom_range(1, 12)),
                         31'($urandom() >> $urandom_range(1, 12)),
                         31'($urandom() >> $urandom_range(1, 12)));
            if (ph == 0) hold_off = 3000;
            repeat (150) particle_q.push_back(rand_particle());
            drain();
        end
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        wait (aresetn);
        // slowest case: both planes projected for every particle plus stalls, several times over
        while (cycles < 2000000) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
rtl/rcrf_pkg.sv
rtl/rcrf_div.sv
rtl/rcrf_datapath.sv
rtl/rcrf_ctrl.sv
rtl/rectangular_collimator_ray_filter_core.sv
rtl/rcrf_checker.sv
test/tb.sv
